@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check, also active during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/ltps_pkg.sv @@
package ltps_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int FIELD_W  = 6;
    localparam int TOTAL_W  = 15;
    localparam int VAL_W    = 3;
    localparam int NPAT     = 8;
    localparam int PAT_W    = 3;
    localparam int Q_DEPTH  = 4;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 56;

    localparam logic [CFG_W-1:0] DIM_MIN = CFG_W'(3);
    localparam logic [CFG_W-1:0] DIM_RST = CFG_W'(8);
    localparam logic [CFG_W-1:0] ROWS_MAX = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(MAX_COLS);

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    localparam logic KIND_POSE  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    // window bit = (1+dr)*3 + (1+dc), centre at bit 4
    localparam logic [3:0] SEC_IDX [NPAT] = '{4'd5, 4'd5, 4'd7, 4'd7, 4'd3, 4'd3, 4'd1, 4'd1};
    localparam logic [3:0] THI_IDX [NPAT] = '{4'd8, 4'd2, 4'd8, 4'd6, 4'd0, 4'd6, 4'd0, 4'd2};

    localparam logic [FIELD_W-1:0] P1 = FIELD_W'(1);
    localparam logic [FIELD_W-1:0] Z0 = '0;
    localparam logic [FIELD_W-1:0] M1 = '1;

    localparam logic [FIELD_W-1:0] DR2 [NPAT] = '{Z0, Z0, P1, P1, Z0, Z0, M1, M1};
    localparam logic [FIELD_W-1:0] DC2 [NPAT] = '{P1, P1, Z0, Z0, M1, M1, Z0, Z0};
    localparam logic [FIELD_W-1:0] DR3 [NPAT] = '{P1, M1, P1, P1, M1, P1, M1, M1};
    localparam logic [FIELD_W-1:0] DC3 [NPAT] = '{P1, P1, P1, M1, M1, M1, M1, P1};

    typedef struct packed {
        logic [NPAT-1:0]    mask;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic               last;
    } t_hit;

    typedef struct packed {
        logic               kind;
        logic [PAT_W-1:0]   pattern;
        logic [FIELD_W-1:0] crow;
        logic [FIELD_W-1:0] ccol;
        logic [FIELD_W-1:0] srow;
        logic [FIELD_W-1:0] scol;
        logic [FIELD_W-1:0] trow;
        logic [FIELD_W-1:0] tcol;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_res;

endpackage

@@ hdl/lattice_tromino_pose_search.sv @@
// A beat's first result passes the input register, expander register and result chain before
// it is offered. One cell is taken per cycle while each yields at most one result and the
// Q_DEPTH-cell chain, which absorbs bursts and output stalls, has room; the expander drains
// one result per cycle; a cell with more results (poses plus any frame total) holds it longer.
// Reset (synchronous, active low): counters, window and pose total clear, frame size 8 x 8.
// The line stores are not cleared; they are written before being read within a frame.
module lattice_tromino_pose_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ltps_pkg::S_DATA_W-1:0]       s_axis_tdata,  // [2:0] cell_value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] pattern_index, [8:3] centre_row, [14:9] centre_col, [20:15] second_row,
    // [26:21] second_col, [32:27] third_row, [38:33] third_col, [53:39] pose_total
    output logic [ltps_pkg::M_DATA_W-1:0]       m_axis_tdata,
    output logic                                m_axis_tuser,  // [0] result_kind
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ltps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ltps_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int CW = ltps_pkg::CFG_W;

    logic [CW-1:0]                  r_rows;
    logic [CW-1:0]                  r_cols;
    logic [ltps_pkg::ROW_W-1:0]     r_row;
    logic [ltps_pkg::COL_W-1:0]     r_col;
    logic [ltps_pkg::ROW_W-1:0]     n_row;
    logic [ltps_pkg::COL_W-1:0]     n_col;

    logic                           r_a_vld;
    logic                           r_a_e;
    logic [ltps_pkg::ROW_W-1:0]     r_a_row;
    logic [ltps_pkg::COL_W-1:0]     r_a_col;
    logic                           r_a_last;
    logic                           r_a_inner;
    logic [8:0]                     r_win;
    logic [8:0]                     n_win;

    logic [CW-1:0]                  rows_eff;
    logic [CW-1:0]                  cols_eff;
    logic                           last_col;
    logic                           last_cell;
    logic                           inner;
    logic                           s_fire;
    logic                           a_move;
    logic                           x_take;
    logic [1:0]                     ram_q;
    ltps_pkg::t_hit                 hit;

    logic                           w_vld  [ltps_pkg::Q_DEPTH+1];
    logic                           w_take [ltps_pkg::Q_DEPTH+1];
    ltps_pkg::t_res                 w_data [ltps_pkg::Q_DEPTH+1];
    ltps_pkg::t_res                 head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ltps_pkg::DIM_RST;
            r_cols <= ltps_pkg::DIM_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ltps_pkg::REG_ROWS: r_rows <= i_cfg_data;
                ltps_pkg::REG_COLS: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign rows_eff = (r_rows < ltps_pkg::DIM_MIN) ? ltps_pkg::DIM_MIN :
                      (r_rows > ltps_pkg::ROWS_MAX) ? ltps_pkg::ROWS_MAX : r_rows;
    assign cols_eff = (r_cols < ltps_pkg::DIM_MIN) ? ltps_pkg::DIM_MIN :
                      (r_cols > ltps_pkg::COLS_MAX) ? ltps_pkg::COLS_MAX : r_cols;

    assign last_col  = CW'(r_col) >= cols_eff - CW'(1);
    assign last_cell = last_col && (CW'(r_row) >= rows_eff - CW'(1));
    assign inner     = (r_row >= ltps_pkg::ROW_W'(2)) && (r_col >= ltps_pkg::COL_W'(2)) &&
                       (CW'(r_row) <= rows_eff - CW'(1)) && (CW'(r_col) <= cols_eff - CW'(1));

    assign s_axis_tready = !r_a_vld || x_take;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign a_move        = r_a_vld && x_take;

    always_comb begin
        n_row = r_row;
        n_col = r_col + ltps_pkg::COL_W'(1);
        if (last_cell) begin
            n_row = '0;
            n_col = '0;
        end else if (last_col) begin
            n_row = r_row + ltps_pkg::ROW_W'(1);
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_a_vld <= 1'b0;
            r_win   <= '0;
        end else begin
            if (s_fire) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (s_axis_tready) begin
                r_a_vld <= s_axis_tvalid;
            end
            if (a_move) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_a_e     <= (s_axis_tdata[ltps_pkg::VAL_W-1:0] == '0);
            r_a_row   <= r_row;
            r_a_col   <= r_col;
            r_a_last  <= last_cell;
            r_a_inner <= inner;
        end
    end

    // entry holds {upper, middle} empty bits of one column
    ltps_ram #(
        .WIDTH(2),
        .DEPTH(ltps_pkg::MAX_COLS)
    ) u_line (
        .i_clk    (i_clk),
        .i_wr_en  (a_move),
        .i_wr_addr(r_a_col),
        .i_wr_data({ram_q[0], r_a_e}),
        .i_rd_en  (s_fire),
        .i_rd_addr(r_col),
        .o_rd_data(ram_q)
    );

    always_comb begin
        n_win[2:0] = {ram_q[1], r_win[2:1]};
        n_win[5:3] = {ram_q[0], r_win[5:4]};
        n_win[8:6] = {r_a_e,    r_win[8:7]};
        hit.row    = ltps_pkg::FIELD_W'(r_a_row);
        hit.col    = ltps_pkg::FIELD_W'(r_a_col);
        hit.last   = r_a_last;
        for (int k = 0; k < ltps_pkg::NPAT; k++) begin
            hit.mask[k] = r_a_inner && n_win[4] &&
                          n_win[ltps_pkg::SEC_IDX[k]] && n_win[ltps_pkg::THI_IDX[k]];
        end
    end

    ltps_expand u_expand (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hit_vld(r_a_vld),
        .i_hit    (hit),
        .o_take   (x_take),
        .o_res_vld(w_vld[0]),
        .o_res    (w_data[0]),
        .i_q_take (w_take[0])
    );

    for (genvar g = 0; g < ltps_pkg::Q_DEPTH; g++) begin : g_chain
        ltps_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (w_vld[g]),
            .i_data (w_data[g]),
            .o_take (w_take[g]),
            .o_vld  (w_vld[g+1]),
            .o_data (w_data[g+1]),
            .i_take (w_take[g+1])
        );
    end

    assign w_take[ltps_pkg::Q_DEPTH] = m_axis_tready;
    assign head                      = w_data[ltps_pkg::Q_DEPTH];

    assign m_axis_tvalid = w_vld[ltps_pkg::Q_DEPTH];
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {2'b00, head.total, head.tcol, head.trow, head.scol, head.srow,
                            head.ccol, head.crow, head.pattern};

endmodule

@@ hdl/ltps_ram.sv @@
module ltps_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

@@ hdl/ltps_cell.sv @@
module ltps_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  ltps_pkg::t_res     i_data,
    output logic               o_take,
    output logic               o_vld,
    output ltps_pkg::t_res     o_data,
    input  logic               i_take
);

    logic           r_vld;
    ltps_pkg::t_res r_data;

    assign o_take = !r_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_data <= i_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

@@ hdl/ltps_expand.sv @@
module ltps_expand (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_hit_vld,
    input  ltps_pkg::t_hit i_hit,
    output logic           o_take,
    output logic           o_res_vld,
    output ltps_pkg::t_res o_res,
    input  logic           i_q_take
);

    logic                                  r_vld;
    logic [ltps_pkg::NPAT-1:0]             r_mask;
    logic [ltps_pkg::FIELD_W-1:0]          r_row;
    logic [ltps_pkg::FIELD_W-1:0]          r_col;
    logic                                  r_last;
    logic [ltps_pkg::TOTAL_W-1:0]          r_cnt;

    logic [ltps_pkg::PAT_W-1:0]            pat;
    logic [ltps_pkg::NPAT-1:0]             rest;
    logic                                  has_pose;
    logic                                  fire;
    logic                                  done;
    logic [ltps_pkg::TOTAL_W-1:0]          cnt_inc;
    logic [ltps_pkg::FIELD_W-1:0]          ci;
    logic [ltps_pkg::FIELD_W-1:0]          cj;

    always_comb begin
        pat = '0;
        for (int i = ltps_pkg::NPAT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pat = ltps_pkg::PAT_W'(i);
            end
        end
    end

    assign rest     = r_mask & (r_mask - ltps_pkg::NPAT'(1));
    assign has_pose = |r_mask;
    assign cnt_inc  = (&r_cnt) ? r_cnt : r_cnt + ltps_pkg::TOTAL_W'(1);
    assign ci       = r_row - ltps_pkg::FIELD_W'(1);
    assign cj       = r_col - ltps_pkg::FIELD_W'(1);

    assign o_res_vld = r_vld && (has_pose || r_last);
    assign fire      = o_res_vld && i_q_take;
    assign done      = r_vld && ((!has_pose && !r_last) ||
                       (fire && (!has_pose || (rest == '0 && !r_last))));
    assign o_take    = !r_vld || done;

    always_comb begin
        o_res = '0;
        if (has_pose) begin
            o_res.kind    = ltps_pkg::KIND_POSE;
            o_res.pattern = pat;
            o_res.crow    = ci;
            o_res.ccol    = cj;
            o_res.srow    = ci + ltps_pkg::DR2[pat];
            o_res.scol    = cj + ltps_pkg::DC2[pat];
            o_res.trow    = ci + ltps_pkg::DR3[pat];
            o_res.tcol    = cj + ltps_pkg::DC3[pat];
            o_res.total   = cnt_inc;
            o_res.last    = (rest == '0) && !r_last;
        end else begin
            o_res.kind  = ltps_pkg::KIND_TOTAL;
            o_res.total = r_cnt;
            o_res.last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (o_take) begin
                r_vld <= i_hit_vld;
            end
            if (fire) begin
                r_cnt <= has_pose ? cnt_inc : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_mask <= i_hit.mask;
            r_row  <= i_hit.row;
            r_col  <= i_hit.col;
            r_last <= i_hit.last;
        end else if (fire && has_pose) begin
            r_mask <= rest;
        end
    end

endmodule

@@ hdl/ltps_checker.sv @@
`include "assert_macros.svh"

module ltps_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [ltps_pkg::S_DATA_W-1:0]       s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [ltps_pkg::M_DATA_W-1:0]       m_axis_tdata,
    input  logic                                m_axis_tuser,
    input  logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [ltps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ltps_pkg::CFG_W-1:0]          i_cfg_data
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")

    `ASSERT_CLK(a_total_closes, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[38:0] == '0), "frame total beat malformed")

    `ASSERT_CLK(a_pose_counted, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[53:39] != '0), "pose beat carries zero total")

    `ASSERT_CLK(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[55:54] == 2'b00), "output pad bits set")

endmodule

bind lattice_tromino_pose_search ltps_checker u_ltps_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ltps_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 4 * (2 + Q_DEPTH);
    localparam int SQUEEZE_CYCLES = 400;
    localparam int ITEM_TARGET    = 160;
    localparam int POSE_CEIL      = 2 ** TOTAL_W - 1;

    localparam int SEC_DR [NPAT] = '{0, 0, 1, 1, 0, 0, -1, -1};
    localparam int SEC_DC [NPAT] = '{1, 1, 0, 0, -1, -1, 0, 0};
    localparam int THI_DR [NPAT] = '{1, -1, 1, 1, -1, 1, -1, -1};
    localparam int THI_DC [NPAT] = '{1, 1, 1, -1, -1, -1, -1, 1};

    localparam logic [VAL_W-1:0] DIRECTED_CELLS [27] = '{
        VAL_W'(0), VAL_W'(0), VAL_W'(0), VAL_W'(0), VAL_W'(0),
        VAL_W'(0), VAL_W'(0), VAL_W'(0), VAL_W'(0),
        VAL_W'(0), VAL_W'(0), VAL_W'(2), VAL_W'(0), VAL_W'(0),
        VAL_W'(-3), VAL_W'(1), VAL_W'(-4), VAL_W'(-1),
        VAL_W'(0), VAL_W'(0), VAL_W'(0), VAL_W'(0), VAL_W'(3),
        VAL_W'(0), VAL_W'(0), VAL_W'(0), VAL_W'(0)
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    lattice_tromino_pose_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    logic [CFG_W-1:0] rows_reg = DIM_RST;
    logic [CFG_W-1:0] cols_reg = DIM_RST;
    bit               upper_bits [MAX_COLS];
    bit               middle_bits [MAX_COLS];
    bit [8:0]         win = '0;
    int               row_ct = 0;
    int               col_ct = 0;
    int               pose_ct = 0;

    t_res             results_due [$];
    logic [VAL_W-1:0] cells_to_send [$];
    int               mismatch_count = 0;
    bit               squeeze_arm = 1'b0;

    function automatic int eff_dim(logic [CFG_W-1:0] v, int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic bit win_at(bit [8:0] w, int dr, int dc);
        return w[(1 + dr) * 3 + (1 + dc)];
    endfunction

    function automatic void step_pose_search(logic [VAL_W-1:0] v);
        int       rows, cols, r, c;
        bit       e, up, mid, last_col, last_cell, have;
        bit [2:0] col_in, rb;
        bit [8:0] w;
        t_res     held;
        rows = eff_dim(rows_reg, MAX_ROWS);
        cols = eff_dim(cols_reg, MAX_COLS);
        r = row_ct;
        c = col_ct;
        e = (v == '0);
        up = 1'b0;
        mid = 1'b0;
        have = 1'b0;
        held = '0;
        w = '0;
        last_col = (c >= cols - 1);
        last_cell = last_col && (r >= rows - 1);
        if (c < MAX_COLS) begin
            up = upper_bits[c];
            mid = middle_bits[c];
            upper_bits[c] = mid;
            middle_bits[c] = e;
        end
        col_in = {e, mid, up};
        for (int t = 0; t < 3; t++) begin
            rb = win[t * 3 +: 3];
            w[t * 3 +: 3] = {col_in[t], rb[2:1]};
        end
        win = w;

        if (r >= 2 && c >= 2 && r <= rows - 1 && c <= cols - 1 && win[4]) begin
            for (int k = 0; k < NPAT; k++) begin
                if (win_at(win, SEC_DR[k], SEC_DC[k]) && win_at(win, THI_DR[k], THI_DC[k])) begin
                    if (pose_ct < POSE_CEIL) pose_ct++;
                    if (have) results_due = {results_due, held};
                    held.kind = KIND_POSE;
                    held.pattern = PAT_W'(k);
                    held.crow = FIELD_W'(r - 1);
                    held.ccol = FIELD_W'(c - 1);
                    held.srow = FIELD_W'(r - 1 + SEC_DR[k]);
                    held.scol = FIELD_W'(c - 1 + SEC_DC[k]);
                    held.trow = FIELD_W'(r - 1 + THI_DR[k]);
                    held.tcol = FIELD_W'(c - 1 + THI_DC[k]);
                    held.total = TOTAL_W'(pose_ct);
                    held.last = 1'b0;
                    have = 1'b1;
                end
            end
        end

        if (last_cell) begin
            if (have) results_due = {results_due, held};
            held = '0;
            held.kind = KIND_TOTAL;
            held.total = TOTAL_W'(pose_ct);
            have = 1'b1;
            pose_ct = 0;
            row_ct = 0;
            col_ct = 0;
        end else if (last_col) begin
            col_ct = 0;
            row_ct = r + 1;
        end else begin
            col_ct = c + 1;
        end

        if (have) begin
            held.last = 1'b1;
            results_due = {results_due, held};
        end
    endfunction

    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // cell driver
    int send_gap = 0;
    int send_calm = 0;
    always @(posedge i_clk) begin
        logic offer;
        offer = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) step_pose_search(cells_to_send.pop_front());
            if (s_axis_tvalid && !s_axis_tready) begin
                offer = 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
            end else if (cells_to_send.size() > 0) begin
                offer = 1'b1;
                s_axis_tdata <= S_DATA_W'(cells_to_send[0]);
                send_gap = pick_gap(send_calm);
            end
        end
        s_axis_tvalid <= offer;
    end

    // result receiver, with one long hold-off once armed
    int recv_stall = 0;
    int recv_calm = 0;
    int squeeze_left = 0;
    bit squeeze_done = 1'b0;
    always @(posedge i_clk) begin
        logic take;
        take = 1'b0;
        if (i_rst_n) begin
            if (squeeze_left > 0) begin
                squeeze_left--;
            end else if (squeeze_arm && !squeeze_done && m_axis_tvalid) begin
                squeeze_done = 1'b1;
                squeeze_left = SQUEEZE_CYCLES;
            end else if (recv_stall > 0) begin
                recv_stall--;
            end else begin
                take = 1'b1;
                if ($urandom_range(0, 3) == 0) recv_stall = pick_gap(recv_calm);
            end
        end
        m_axis_tready <= take;
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                $error("result beat with no expected result pending");
                mismatch_count++;
            end else begin
                want = results_due.pop_front();
                check_field("result_kind", want.kind, m_axis_tuser);
                check_field("pattern_index", want.pattern, m_axis_tdata[2:0]);
                check_field("centre_row", want.crow, m_axis_tdata[8:3]);
                check_field("centre_col", want.ccol, m_axis_tdata[14:9]);
                check_field("second_row", want.srow, m_axis_tdata[20:15]);
                check_field("second_col", want.scol, m_axis_tdata[26:21]);
                check_field("third_row", want.trow, m_axis_tdata[32:27]);
                check_field("third_col", want.tcol, m_axis_tdata[38:33]);
                check_field("pose_total", want.total, m_axis_tdata[53:39]);
                check_field("run_last", want.last, m_axis_tlast);
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int queue_random_frame(int dens_lo);
        int dens, n;
        dens = $urandom_range(dens_lo, 9);
        n = eff_dim(rows_reg, MAX_ROWS) * eff_dim(cols_reg, MAX_COLS);
        repeat (n) begin
            if ($urandom_range(0, 9) < dens) cells_to_send = {cells_to_send, VAL_W'(0)};
            else cells_to_send = {cells_to_send, VAL_W'($urandom_range(0, 7))};
        end
        return n;
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 3) return CFG_W'($urandom_range(0, 2));
        return CFG_W'($urandom_range(3, 5));
    endfunction

    task automatic wait_idle();
        while (cells_to_send.size() > 0 || s_axis_tvalid || results_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dims(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_ROWS;
        i_cfg_data <= rows;
        do @(posedge i_clk); while (!o_cfg_ready);
        rows_reg = rows;
        i_cfg_index <= REG_COLS;
        i_cfg_data <= cols;
        do @(posedge i_clk); while (!o_cfg_ready);
        cols_reg = cols;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int sent_total;
        sent_total = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sent_total += queue_random_frame(3);

        write_dims(DIM_MIN, DIM_MIN);
        foreach (DIRECTED_CELLS[i]) cells_to_send = {cells_to_send, DIRECTED_CELLS[i]};
        sent_total += $size(DIRECTED_CELLS);

        // squeeze the output while a dense frame streams in
        write_dims(CFG_W'(1), CFG_W'(12));
        squeeze_arm = 1'b1;
        sent_total += queue_random_frame(8);

        write_dims(CFG_W'(4), '0);
        sent_total += queue_random_frame(3);

        while (sent_total < ITEM_TARGET) begin
            write_dims(pick_dim(), pick_dim());
            sent_total += queue_random_frame(3);
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
